// File: rtl/core/bup_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_pkg: shared constants and types of the bilinear upscaler
// Frame geometry, fixed-point scale factors, bank layout of the frame store
// and the command word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package bup_pkg;

  // Frame geometry
  localparam int SRC_H = 60;
  localparam int SRC_W = 94;
  localparam int DST_H = 120;
  localparam int DST_W = 188;

  // Field widths of the channels
  localparam int PIX_W = 8;
  localparam int IDX_W = 13;
  localparam int ROW_W = 7;
  localparam int COL_W = 8;

  // Action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_REQ  = 1'b1;

  // Fixed-point format of source coordinates
  localparam int FRAC_BITS = 8;
  localparam int FRAC_ONE  = 1 << FRAC_BITS;
  localparam int WT_W      = FRAC_BITS + 1;
  localparam int ROUND     = 1 << (2 * FRAC_BITS - 1);

  localparam int STORE_DEPTH = SRC_H * SRC_W;

  localparam int SCALE_Y = (SRC_H << FRAC_BITS) / DST_H;
  localparam int SCALE_X = (SRC_W << FRAC_BITS) / DST_W;
  localparam int SCY_W   = $clog2(SCALE_Y + 1);
  localparam int SCX_W   = $clog2(SCALE_X + 1);

  // Scaled destination coordinate, at least one bit above the fraction
  localparam int FY_W = (ROW_W + SCY_W > FRAC_BITS) ? (ROW_W + SCY_W) : (FRAC_BITS + 1);
  localparam int FX_W = (COL_W + SCX_W > FRAC_BITS) ? (COL_W + SCX_W) : (FRAC_BITS + 1);

  // Source coordinate widths
  localparam int Y_W = $clog2(SRC_H);
  localparam int X_W = $clog2(SRC_W);

  // Integer part of the scaled coordinate before clamping
  localparam int IY_W = (FY_W - FRAC_BITS > Y_W) ? (FY_W - FRAC_BITS) : Y_W;
  localparam int IX_W = (FX_W - FRAC_BITS > X_W) ? (FX_W - FRAC_BITS) : X_W;

  // Reciprocal of the row length for splitting a linear index into row/col
  localparam int RECIP   = (1 << IDX_W) / SRC_W;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = IDX_W + RECIP_W;

  // Frame store split into four banks by row and column parity
  localparam int BANK_ROWS  = (SRC_H + 1) / 2;
  localparam int BANK_COLS  = (SRC_W + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Blend arithmetic
  localparam int TOP_W = PIX_W + FRAC_BITS;
  localparam int SUM_W = PIX_W + 2 * FRAC_BITS;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                 is_req;
    logic [Y_W-1:0]       y;
    logic [X_W-1:0]       x;
    logic [PIX_W-1:0]     pixel;
    logic [FRAC_BITS-1:0] wy;
    logic [FRAC_BITS-1:0] wx;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_bus_t;

endpackage

// File: rtl/core/bup_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_ram: generic RAM, one write port and one registered read port
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
module bup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: rtl/core/bup_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_front: input stage of the upscaler
// Accepts words, drops out-of-range loads, splits load indices into row and
// column and maps requests onto clamped source coordinates with weights.
// ----------------------------------------------------------------------------
module bup_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [bup_pkg::IDX_W-1:0]     in_src_index,
  input  logic [bup_pkg::PIX_W-1:0]     in_src_pixel,
  input  logic [bup_pkg::ROW_W-1:0]     in_out_row,
  input  logic [bup_pkg::COL_W-1:0]     in_out_col,
  input  logic [bup_pkg::QC_W-1:0]      q_level,
  output bup_pkg::cmd_bus_t             push_o
);

  logic                          take;
  logic                          keep;
  logic                          in_range;
  logic [bup_pkg::QC_W:0]        level_sum;

  logic                          f1_valid_r;
  logic                          f1_req_r;
  logic [bup_pkg::IDX_W-1:0]     f1_idx_r;
  logic [bup_pkg::PIX_W-1:0]     f1_pixel_r;
  logic [bup_pkg::PROD_W-1:0]    f1_prod_r;
  logic [bup_pkg::FY_W-1:0]      f1_fy_r;
  logic [bup_pkg::FX_W-1:0]      f1_fx_r;
  logic                          f1_last_r;

  logic [bup_pkg::PROD_W-1:0]    prod_nxt;
  logic [bup_pkg::FY_W-1:0]      fy_nxt;
  logic [bup_pkg::FX_W-1:0]      fx_nxt;
  logic                          last_nxt;

  logic [bup_pkg::IDX_W-1:0]     q_est;
  logic [bup_pkg::IDX_W-1:0]     q_fix;
  logic [bup_pkg::IDX_W-1:0]     rem0;
  logic [bup_pkg::IDX_W-1:0]     rem;
  logic [bup_pkg::IY_W-1:0]      iy;
  logic [bup_pkg::IX_W-1:0]      ix;
  logic [bup_pkg::IY_W-1:0]      iy_c;
  logic [bup_pkg::IX_W-1:0]      ix_c;

  // Items in the register stage count against queue space
  assign level_sum = (bup_pkg::QC_W + 1)'(q_level) + (bup_pkg::QC_W + 1)'(f1_valid_r);
  assign in_stall  = level_sum >= (bup_pkg::QC_W + 1)'(bup_pkg::QUEUE_DEPTH);
  assign take      = in_valid && !in_stall;
  assign in_range  = 32'(in_src_index) < 32'(bup_pkg::STORE_DEPTH);
  assign keep      = take && ((in_action == bup_pkg::ACT_REQ) || in_range);

  assign prod_nxt = bup_pkg::PROD_W'(in_src_index * bup_pkg::RECIP);
  assign fy_nxt   = bup_pkg::FY_W'(in_out_row * bup_pkg::SCALE_Y);
  assign fx_nxt   = bup_pkg::FX_W'(in_out_col * bup_pkg::SCALE_X);
  assign last_nxt = (32'(in_out_row) == 32'(bup_pkg::DST_H - 1)) &&
                    (32'(in_out_col) == 32'(bup_pkg::DST_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= keep;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f1_req_r   <= (in_action == bup_pkg::ACT_REQ);
      f1_idx_r   <= in_src_index;
      f1_pixel_r <= in_src_pixel;
      f1_prod_r  <= prod_nxt;
      f1_fy_r    <= fy_nxt;
      f1_fx_r    <= fx_nxt;
      f1_last_r  <= last_nxt;
    end
  end

  // Index split: reciprocal estimate is exact or one low
  always_comb begin
    q_est = bup_pkg::IDX_W'(f1_prod_r >> bup_pkg::IDX_W);
    rem0  = f1_idx_r - bup_pkg::IDX_W'(q_est * bup_pkg::SRC_W);
    if (rem0 >= bup_pkg::IDX_W'(bup_pkg::SRC_W)) begin
      q_fix = q_est + bup_pkg::IDX_W'(1);
      rem   = rem0 - bup_pkg::IDX_W'(bup_pkg::SRC_W);
    end else begin
      q_fix = q_est;
      rem   = rem0;
    end
  end

  // Clamp integer parts so the 2x2 neighbourhood stays in the frame
  always_comb begin
    iy = bup_pkg::IY_W'(f1_fy_r >> bup_pkg::FRAC_BITS);
    ix = bup_pkg::IX_W'(f1_fx_r >> bup_pkg::FRAC_BITS);
    if (iy >= bup_pkg::IY_W'(bup_pkg::SRC_H - 1)) begin
      iy_c = bup_pkg::IY_W'(bup_pkg::SRC_H - 2);
    end else begin
      iy_c = iy;
    end
    if (ix >= bup_pkg::IX_W'(bup_pkg::SRC_W - 1)) begin
      ix_c = bup_pkg::IX_W'(bup_pkg::SRC_W - 2);
    end else begin
      ix_c = ix;
    end
  end

  always_comb begin
    push_o            = '0;
    push_o.valid      = f1_valid_r;
    push_o.cmd.is_req = f1_req_r;
    push_o.cmd.pixel  = f1_pixel_r;
    push_o.cmd.wy     = f1_fy_r[bup_pkg::FRAC_BITS-1:0];
    push_o.cmd.wx     = f1_fx_r[bup_pkg::FRAC_BITS-1:0];
    push_o.cmd.last   = f1_last_r;
    if (f1_req_r) begin
      push_o.cmd.y = bup_pkg::Y_W'(iy_c);
      push_o.cmd.x = bup_pkg::X_W'(ix_c);
    end else begin
      push_o.cmd.y = bup_pkg::Y_W'(q_fix);
      push_o.cmd.x = bup_pkg::X_W'(rem);
    end
  end

  ap_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.valid |-> (q_level < bup_pkg::QC_W'(bup_pkg::QUEUE_DEPTH)))
    else $error("front pushed into a full queue");

endmodule

// File: rtl/core/bup_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_queue: short command queue between front and back
// Register-based FIFO; head word is visible whenever the queue is not empty.
// ----------------------------------------------------------------------------
module bup_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bup_pkg::cmd_bus_t        push_i,
  input  logic                     pop_i,
  output bup_pkg::cmd_bus_t        head_o,
  output logic [bup_pkg::QC_W-1:0] level_o
);

  bup_pkg::cmd_t               q_mem_r [bup_pkg::QUEUE_DEPTH];
  logic [bup_pkg::QP_W-1:0]    wr_ptr_r;
  logic [bup_pkg::QP_W-1:0]    rd_ptr_r;
  logic [bup_pkg::QC_W-1:0]    count_r;
  logic [bup_pkg::QP_W-1:0]    wr_ptr_nxt;
  logic [bup_pkg::QP_W-1:0]    rd_ptr_nxt;
  logic [bup_pkg::QC_W-1:0]    count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i.valid) begin
      wr_ptr_nxt = (wr_ptr_r == bup_pkg::QP_W'(bup_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + bup_pkg::QP_W'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == bup_pkg::QP_W'(bup_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + bup_pkg::QP_W'(1);
    end
    count_nxt = count_r + bup_pkg::QC_W'(push_i.valid) - bup_pkg::QC_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      q_mem_r[wr_ptr_r] <= push_i.cmd;
    end
  end

  assign head_o.valid = (count_r != '0);
  assign head_o.cmd   = q_mem_r[rd_ptr_r];
  assign level_o      = count_r;

  ap_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("queue popped while empty");

  ap_level_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r) + bup_pkg::QC_W'($past(push_i.valid))
                                         - bup_pkg::QC_W'($past(pop_i))))
    else $error("queue level does not follow push and pop");

  ap_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (bup_pkg::QP_W'(wr_ptr_r - rd_ptr_r) == bup_pkg::QP_W'(count_r)))
    else $error("queue pointers disagree with level");

endmodule

// File: rtl/core/bup_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_back: frame store and blend pipeline
// Four parity banks give the 2x2 neighbourhood in one read; a horizontal
// blend stage follows, and the vertical blend feeds the output register.
// ----------------------------------------------------------------------------
module bup_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bup_pkg::cmd_bus_t           head_i,
  output logic                        pop_o,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bup_pkg::PIX_W-1:0]   out_pixel,
  output logic                        out_is_last
);

  logic                           advance;
  logic                           issue_rd;
  logic                           issue_wr;
  logic [bup_pkg::Y_W-1:0]        y_plus;
  logic [bup_pkg::X_W-1:0]        x_plus;
  logic [bup_pkg::Y_W-1:0]        row_sel  [2];
  logic [bup_pkg::X_W-1:0]        col_sel  [2];
  logic [bup_pkg::BA_W-1:0]       row_base [2];
  logic [bup_pkg::BA_W-1:0]       bank_addr [2][2];
  logic                           bank_we   [2][2];
  logic [bup_pkg::PIX_W-1:0]      bank_q    [2][2];

  logic                           b1_valid_r;
  logic                           b1_y0_r;
  logic                           b1_x0_r;
  logic [bup_pkg::FRAC_BITS-1:0]  b1_wx_r;
  logic [bup_pkg::FRAC_BITS-1:0]  b1_wy_r;
  logic                           b1_last_r;

  logic [bup_pkg::PIX_W-1:0]      r0c0, r0c1, r1c0, r1c1;
  logic [bup_pkg::PIX_W-1:0]      p00, p01, p10, p11;
  logic [bup_pkg::WT_W-1:0]       inv_wx;
  logic [bup_pkg::WT_W-1:0]       inv_wy;
  logic [bup_pkg::TOP_W-1:0]      top_nxt;
  logic [bup_pkg::TOP_W-1:0]      bot_nxt;

  logic                           b2_valid_r;
  logic [bup_pkg::TOP_W-1:0]      b2_top_r;
  logic [bup_pkg::TOP_W-1:0]      b2_bot_r;
  logic [bup_pkg::FRAC_BITS-1:0]  b2_wy_r;
  logic                           b2_last_r;

  logic [bup_pkg::SUM_W-1:0]      sum_nxt;

  logic                           out_valid_r;
  logic [bup_pkg::PIX_W-1:0]      out_pixel_r;
  logic                           out_last_r;

  // Whole back pipeline moves together; it holds only when the output stalls
  assign advance  = !out_valid_r || !out_stall;
  assign pop_o    = advance && head_i.valid;
  assign issue_rd = pop_o && head_i.cmd.is_req;
  assign issue_wr = pop_o && !head_i.cmd.is_req;

  // Bank addresses: each parity bank holds exactly one of the four neighbours
  always_comb begin
    y_plus = head_i.cmd.y + bup_pkg::Y_W'(1);
    x_plus = head_i.cmd.x + bup_pkg::X_W'(1);
    for (int p = 0; p < 2; p++) begin
      row_sel[p]  = (head_i.cmd.y[0] == 1'(p)) ? (head_i.cmd.y >> 1) : (y_plus >> 1);
      col_sel[p]  = (head_i.cmd.x[0] == 1'(p)) ? (head_i.cmd.x >> 1) : (x_plus >> 1);
      row_base[p] = bup_pkg::BA_W'(row_sel[p] * bup_pkg::BANK_COLS);
    end
    for (int py = 0; py < 2; py++) begin
      for (int px = 0; px < 2; px++) begin
        bank_addr[py][px] = row_base[py] + bup_pkg::BA_W'(col_sel[px]);
        bank_we[py][px]   = issue_wr && (head_i.cmd.y[0] == 1'(py)) &&
                            (head_i.cmd.x[0] == 1'(px));
      end
    end
  end

  for (genvar gy = 0; gy < 2; gy++) begin : g_row
    for (genvar gx = 0; gx < 2; gx++) begin : g_col
      bup_ram #(
        .WIDTH(bup_pkg::PIX_W),
        .DEPTH(bup_pkg::BANK_DEPTH)
      ) u_bank (
        .clk  (clk),
        .we   (bank_we[gy][gx]),
        .waddr(bank_addr[gy][gx]),
        .wdata(head_i.cmd.pixel),
        .re   (issue_rd),
        .raddr(bank_addr[gy][gx]),
        .rdata(bank_q[gy][gx])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b1_valid_r  <= issue_rd;
      b2_valid_r  <= b1_valid_r;
      out_valid_r <= b2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_rd) begin
      b1_y0_r   <= head_i.cmd.y[0];
      b1_x0_r   <= head_i.cmd.x[0];
      b1_wx_r   <= head_i.cmd.wx;
      b1_wy_r   <= head_i.cmd.wy;
      b1_last_r <= head_i.cmd.last;
    end
  end

  // Undo the parity interleave, then blend along the row
  always_comb begin
    r0c0 = b1_y0_r ? bank_q[1][0] : bank_q[0][0];
    r0c1 = b1_y0_r ? bank_q[1][1] : bank_q[0][1];
    r1c0 = b1_y0_r ? bank_q[0][0] : bank_q[1][0];
    r1c1 = b1_y0_r ? bank_q[0][1] : bank_q[1][1];
    p00  = b1_x0_r ? r0c1 : r0c0;
    p01  = b1_x0_r ? r0c0 : r0c1;
    p10  = b1_x0_r ? r1c1 : r1c0;
    p11  = b1_x0_r ? r1c0 : r1c1;
    inv_wx  = bup_pkg::WT_W'(bup_pkg::FRAC_ONE) - bup_pkg::WT_W'(b1_wx_r);
    top_nxt = bup_pkg::TOP_W'(p00) * bup_pkg::TOP_W'(inv_wx) +
              bup_pkg::TOP_W'(p01) * bup_pkg::TOP_W'(b1_wx_r);
    bot_nxt = bup_pkg::TOP_W'(p10) * bup_pkg::TOP_W'(inv_wx) +
              bup_pkg::TOP_W'(p11) * bup_pkg::TOP_W'(b1_wx_r);
  end

  always_ff @(posedge clk) begin
    if (advance && b1_valid_r) begin
      b2_top_r  <= top_nxt;
      b2_bot_r  <= bot_nxt;
      b2_wy_r   <= b1_wy_r;
      b2_last_r <= b1_last_r;
    end
  end

  // Blend the two rows and round
  always_comb begin
    inv_wy  = bup_pkg::WT_W'(bup_pkg::FRAC_ONE) - bup_pkg::WT_W'(b2_wy_r);
    sum_nxt = bup_pkg::SUM_W'(b2_top_r) * bup_pkg::SUM_W'(inv_wy) +
              bup_pkg::SUM_W'(b2_bot_r) * bup_pkg::SUM_W'(b2_wy_r) +
              bup_pkg::SUM_W'(bup_pkg::ROUND);
  end

  always_ff @(posedge clk) begin
    if (advance && b2_valid_r) begin
      out_pixel_r <= sum_nxt[bup_pkg::SUM_W-1 -: bup_pkg::PIX_W];
      out_last_r  <= b2_last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel   = out_pixel_r;
  assign out_is_last = out_last_r;

endmodule

// File: rtl/core/bilinear_image_upscale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_upscale: bilinear upscaler for an 8-bit grey frame
// Load words fill a 60x94 frame store; request words name a 120x188
// destination position and return one interpolated pixel.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in_      | input     | in_valid / in_stall | action, src_index, src_pixel,
//           |           |                     | out_row, out_col
//  out_     | output    | out_valid/out_stall | out_pixel, is_last
//
//  Throughput is one word per cycle while no stall holds the flow, loads
//  and requests alike, set by the four parity banks of the frame store
//  that return all four neighbours in one read. A request passes through the
//  input register, queue, bank read, row blend, then the output register.
//  Reset clears control state only; the frame store is not cleared and an
//  entry reads undefined until loaded. An output stall holds the back end;
//  the front keeps accepting until the input register and the four-entry
//  command queue together hold four words.
//
module bilinear_image_upscale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [bup_pkg::IDX_W-1:0]   in_src_index,
  input  logic [bup_pkg::PIX_W-1:0]   in_src_pixel,
  input  logic [bup_pkg::ROW_W-1:0]   in_out_row,
  input  logic [bup_pkg::COL_W-1:0]   in_out_col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bup_pkg::PIX_W-1:0]   out_pixel,
  output logic                        out_is_last
);

  bup_pkg::cmd_bus_t          push_bus;
  bup_pkg::cmd_bus_t          head_bus;
  logic                       pop;
  logic [bup_pkg::QC_W-1:0]   q_level;

  // Front: register the word, drop out-of-range loads, split load indices
  // into row/column and turn requests into clamped coordinates plus weights.
  bup_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_src_index(in_src_index),
    .in_src_pixel(in_src_pixel),
    .in_out_row  (in_out_row),
    .in_out_col  (in_out_col),
    .q_level     (q_level),
    .push_o      (push_bus)
  );

  // Queue: keeps loads and requests in order so a write always lands
  // before any later read of the same entry.
  bup_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push_bus),
    .pop_i  (pop),
    .head_o (head_bus),
    .level_o(q_level)
  );

  // Back: write or read the banks, blend, round and present the result.
  bup_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_i     (head_bus),
    .pop_o      (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pixel  (out_pixel),
    .out_is_last(out_is_last)
  );

endmodule

// File: bench/bilinear_image_upscale_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_upscale_test: self-checking bench of the bilinear upscaler
// Loads source pixels into the frame store and requests interpolated
// destination pixels. Each request is only aimed at a neighbourhood that has
// already been loaded. A scoreboard holds the interpolated value and the
// end-of-frame flag computed at acceptance and matches them in order against
// the output words. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module bilinear_image_upscale_test;
  import bup_pkg::*;

  localparam int RANDOM_WORDS   = 1550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int ROW_MAX        = (1 << ROW_W) - 1;
  localparam int COL_MAX        = (1 << COL_W) - 1;
  localparam int IDX_MAX        = (1 << IDX_W) - 1;

  // One word of the input channel
  typedef struct packed {
    logic             act;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } in_word_t;

  // Expected output word
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } pixel_due_t;

  // Integer source position and fractions of one destination position
  typedef struct {
    int unsigned yi;
    int unsigned xi;
    int unsigned wy;
    int unsigned wx;
  } src_pos_t;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic             in_action    = ACT_LOAD;
  logic [IDX_W-1:0] in_src_index = '0;
  logic [PIX_W-1:0] in_src_pixel = '0;
  logic [ROW_W-1:0] in_out_row   = '0;
  logic [COL_W-1:0] in_out_col   = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [PIX_W-1:0] out_pixel;
  logic             out_is_last;

  // Stimulus side: words waiting for the driver, plus the generator's view
  // of which source entries and 2x2 neighbourhoods are already loaded
  in_word_t   word_q[$];
  bit         src_written [STORE_DEPTH];
  bit         cell_ready  [STORE_DEPTH];
  int         ready_cells[$];
  int         n_words;

  // Checking side: the bench's own copy of the frame store and the pixels due
  logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
  pixel_due_t       pixel_due_q[$];
  pixel_due_t       due;
  int               mismatch_count;
  int               idle_cycles;
  bit               in_fire = 1'b0;

  // Driver and stall state
  in_word_t next_word;
  int       gap_left;
  bit       burst_mode;
  int       stall_left;
  int       stall_pct = 25;

  bilinear_image_upscale i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_src_index (in_src_index),
    .in_src_pixel (in_src_pixel),
    .in_out_row   (in_out_row),
    .in_out_col   (in_out_col),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel),
    .out_is_last  (out_is_last)
  );

  always #5 clk = ~clk;

  // Map a destination position onto the source grid: 8 fraction bits,
  // integer part clamped to size - 2, fraction left as computed.
  function automatic src_pos_t map_position(int unsigned row, int unsigned col);
    src_pos_t    p;
    int unsigned fy;
    int unsigned fx;
    fy   = row * SCALE_Y;
    fx   = col * SCALE_X;
    p.yi = fy >> FRAC_BITS;
    p.xi = fx >> FRAC_BITS;
    if (p.yi >= SRC_H - 1) p.yi = SRC_H - 2;
    if (p.xi >= SRC_W - 1) p.xi = SRC_W - 2;
    p.wy = fy & (FRAC_ONE - 1);
    p.wx = fx & (FRAC_ONE - 1);
    return p;
  endfunction

  // Blend the four neighbours along the row, then down the column, and round.
  function automatic pixel_due_t interpolate_pixel(int unsigned row, int unsigned col);
    pixel_due_t  r;
    src_pos_t    p;
    int unsigned base;
    int unsigned upper;
    int unsigned lower;
    int unsigned acc;
    p     = map_position(row, col);
    base  = p.yi * SRC_W + p.xi;
    upper = frame_mem[base] * (FRAC_ONE - p.wx) + frame_mem[base + 1] * p.wx;
    lower = frame_mem[base + SRC_W] * (FRAC_ONE - p.wx)
          + frame_mem[base + SRC_W + 1] * p.wx;
    acc   = upper * (FRAC_ONE - p.wy) + lower * p.wy;
    r.pix  = PIX_W'((acc + ROUND) >> (2 * FRAC_BITS));
    r.last = (row == DST_H - 1) && (col == DST_W - 1);
    return r;
  endfunction

  // Bias pixel values toward black and white
  function automatic int draw_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return (1 << PIX_W) - 1;
    return $urandom_range(0, (1 << PIX_W) - 1);
  endfunction

  // Record a load and flag every 2x2 neighbourhood it completes
  task automatic note_written(int idx);
    int r;
    int c;
    int cy;
    int cx;
    int b;
    src_written[idx] = 1'b1;
    r = idx / SRC_W;
    c = idx % SRC_W;
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        cy = r - dy;
        cx = c - dx;
        if (cy >= 0 && cy <= SRC_H - 2 && cx >= 0 && cx <= SRC_W - 2) begin
          b = cy * SRC_W + cx;
          if (!cell_ready[b] && src_written[b] && src_written[b + 1] &&
              src_written[b + SRC_W] && src_written[b + SRC_W + 1]) begin
            cell_ready[b] = 1'b1;
            ready_cells.push_back(b);
          end
        end
      end
    end
  endtask

  // Queue a load word; request fields carry noise. Ignored loads do not count.
  task automatic push_load(int idx, int pix);
    in_word_t w;
    w.act = ACT_LOAD;
    w.idx = IDX_W'(idx);
    w.pix = PIX_W'(pix);
    w.row = ROW_W'($urandom);
    w.col = COL_W'($urandom);
    word_q.push_back(w);
    if (idx < STORE_DEPTH) begin
      note_written(idx);
      n_words++;
    end
  endtask

  // Queue a request word; load fields carry noise
  task automatic push_request(int row, int col);
    in_word_t w;
    w.act = ACT_REQ;
    w.idx = IDX_W'($urandom);
    w.pix = PIX_W'($urandom);
    w.row = ROW_W'(row);
    w.col = COL_W'(col);
    word_q.push_back(w);
    n_words++;
  endtask

  // Request a position whose four neighbours are loaded. Try a fully random
  // position first now and then; otherwise pick a ready neighbourhood and
  // aim at it (2x upscale on both axes, so source k covers 2k and 2k+1).
  // The clamped last row and column also cover everything beyond the frame.
  task automatic push_random_request();
    src_pos_t p;
    int       row;
    int       col;
    int       nbr;
    int       yi;
    int       xi;
    if ($urandom_range(0, 99) < 30) begin
      row = $urandom_range(0, ROW_MAX);
      col = $urandom_range(0, COL_MAX);
      p   = map_position(row, col);
      if (cell_ready[p.yi * SRC_W + p.xi]) begin
        push_request(row, col);
        return;
      end
    end
    nbr  = ready_cells[$urandom_range(0, ready_cells.size() - 1)];
    yi   = nbr / SRC_W;
    xi   = nbr % SRC_W;
    row  = (yi == SRC_H - 2) ? $urandom_range(2 * yi, ROW_MAX) : 2 * yi + $urandom_range(0, 1);
    col  = (xi == SRC_W - 2) ? $urandom_range(2 * xi, COL_MAX) : 2 * xi + $urandom_range(0, 1);
    push_request(row, col);
  endtask

  // Input gaps: mostly none or short, a few long, none at all in bursts
  function automatic int draw_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: present the next word at the falling edge once the current one
  // has gone, after its gap. Hold the word while it is stalled.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        next_word     = word_q.pop_front();
        in_action    <= next_word.act;
        in_src_index <= next_word.idx;
        in_src_pixel <= next_word.pix;
        in_out_row   <= next_word.row;
        in_out_col   <= next_word.col;
        in_valid     <= 1'b1;
        gap_left      = draw_gap();
        if ($urandom_range(0, 99) < 2) burst_mode = !burst_mode;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: the stall rate drifts between none, light and heavy; now
  // and then a stall runs long.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          default: stall_pct = 60;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall  <= 1'b1;
        stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: at the rising edge, update the store copy on loads, queue the
  // pixel due for each request, match output words in order, and watch for
  // a stuck pipe.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire     <= 1'b0;
      idle_cycles  = 0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (in_action == ACT_LOAD) begin
          if (in_src_index < STORE_DEPTH) frame_mem[in_src_index] = in_src_pixel;
        end else begin
          pixel_due_q.push_back(interpolate_pixel(in_out_row, in_out_col));
        end
      end
      if (out_valid && !out_stall) begin
        if (pixel_due_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected word pixel=%0d is_last=%0b",
                     $realtime, out_pixel, out_is_last);
        end else begin
          due = pixel_due_q.pop_front();
          if (out_pixel !== due.pix || out_is_last !== due.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch pixel exp=%0d got=%0d is_last exp=%0b got=%0b",
                       $realtime, due.pix, out_pixel, due.last, out_is_last);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    int       h;
    int       w;
    int       y0;
    int       x0;
    int       n_req;
    int       r;
    int       j;
    int       tmp;
    int       win_q[$];
    int       br;

    // Directed: load the top-left neighbourhood with extreme values and the
    // bottom-right one, the last store entry among them.
    br = (SRC_H - 2) * SRC_W + (SRC_W - 2);
    push_load(0, 255);
    push_load(1, 0);
    push_load(SRC_W, 0);
    push_load(SRC_W + 1, 255);
    push_load(br, 255);
    push_load(br + 1, 17);
    push_load(br + SRC_W, 200);
    push_load(STORE_DEPTH - 1, 0);
    // Loads past the end of the store are dropped
    push_load(STORE_DEPTH, 255);
    push_load(IDX_MAX, 255);
    // Corner, half-way and centre positions, the last pixel of the frame,
    // its neighbours, and positions beyond the frame that clamp
    push_request(0, 0);
    push_request(0, 1);
    push_request(1, 1);
    push_request(DST_H - 1, DST_W - 1);
    push_request(DST_H - 1, DST_W - 2);
    push_request(DST_H - 2, DST_W - 1);
    push_request(DST_H, DST_W);
    push_request(ROW_MAX, COL_MAX);
    // Overwrite behind a request, then read again
    push_load(0, 1);
    push_request(0, 0);

    // Random: load small windows (often at the frame edges) in scrambled
    // order, interleaved with requests into loaded areas and stray loads.
    while (n_words < RANDOM_WORDS) begin
      h  = $urandom_range(2, 6);
      w  = $urandom_range(2, 8);
      r  = $urandom_range(0, 99);
      y0 = (r < 20) ? SRC_H - h : (r < 35) ? 0 : $urandom_range(0, SRC_H - h);
      r  = $urandom_range(0, 99);
      x0 = (r < 20) ? SRC_W - w : (r < 35) ? 0 : $urandom_range(0, SRC_W - w);
      for (int y = y0; y < y0 + h; y++)
        for (int x = x0; x < x0 + w; x++)
          win_q.push_back(y * SRC_W + x);
      for (int i = win_q.size() - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = win_q[i];
        win_q[i] = win_q[j];
        win_q[j] = tmp;
      end
      n_req = $urandom_range(8, 30);
      while (win_q.size() != 0 || n_req > 0) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          push_load($urandom_range(0, IDX_MAX), draw_pixel());
        end else if (win_q.size() != 0 && (r < 60 || n_req == 0)) begin
          push_load(win_q.pop_front(), draw_pixel());
        end else begin
          push_random_request();
          n_req--;
        end
      end
    end

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all words sent and every pixel due has arrived
    while (word_q.size() != 0 || in_valid || pixel_due_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bup_pkg.sv
rtl/core/bup_ram.sv
rtl/core/bup_front.sv
rtl/core/bup_queue.sv
rtl/core/bup_back.sv
rtl/core/bilinear_image_upscale.sv
bench/bilinear_image_upscale_test.sv
